FILE: rtl/core/i2d_pkg.sv
// shared constants and types for the decimal ascii converter
// no dependencies
package i2d_pkg;

  localparam int VALUE_WIDTH = 64;
  // decimal digits needed for the largest unsigned value: ceil(width * log10(2))
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103 + 99999) / 100000;
  localparam int BCD_WIDTH   = NUM_DIGITS * 4;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // status handed from the bcd converter to the character emitter
  typedef struct packed {
    logic done;
    logic neg;
  } cvt_status_t;

endpackage

FILE: rtl/core/i2d_dabble.sv
// bit-serial binary to bcd converter (shift and add-3), one bit per cycle
// depends on i2d_pkg
module i2d_dabble
  import i2d_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   neg_i,
  input  logic [VALUE_WIDTH-1:0] mag_i,
  output logic                   busy_o,
  output cvt_status_t            status_o,
  output logic [BCD_WIDTH-1:0]   bcd_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic                   neg_q, neg_d;
  logic [BIT_CNT_W-1:0]   cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_WIDTH-1:0]   bcd_q, bcd_d;
  logic [BCD_WIDTH-1:0]   adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = neg_i;
      cnt_d  = BIT_CNT_W'(VALUE_WIDTH);
      bin_d  = mag_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_WIDTH-2:0], bin_q[VALUE_WIDTH-1]};
      bin_d = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - BIT_CNT_W'(1);
      if (cnt_q == BIT_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign busy_o        = busy_q | done_q;
  assign status_o.done = done_q;
  assign status_o.neg  = neg_q;
  assign bcd_o         = bcd_q;

endmodule

FILE: rtl/core/i2d_emit.sv
// character emitter: drops leading zeros, sends sign and digits msd first
// depends on i2d_pkg
module i2d_emit
  import i2d_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cvt_status_t          status_i,
  input  logic [BCD_WIDTH-1:0] bcd_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           text_char_o,
  output logic                 last_char_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [BCD_WIDTH-1:0] dig_q, dig_d;
  logic [DIG_CNT_W-1:0] cnt_q, cnt_d;
  logic                 sign_q, sign_d;
  logic                 valid_q, valid_d;
  logic [7:0]           char_q, char_d;
  logic                 last_q, last_d;
  logic [3:0]           top_dig;
  logic                 take;

  assign top_dig = dig_q[BCD_WIDTH-1 -: 4];
  assign take    = !valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    cnt_d   = cnt_q;
    sign_d  = sign_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (take) begin
      valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (status_i.done) begin
          dig_d   = bcd_i;
          cnt_d   = DIG_CNT_W'(NUM_DIGITS);
          sign_d  = status_i.neg;
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // one leading zero a cycle, always keep the last digit
        if (cnt_q != DIG_CNT_W'(1) && top_dig == 4'd0) begin
          dig_d = {dig_q[BCD_WIDTH-5:0], 4'd0};
          cnt_d = cnt_q - DIG_CNT_W'(1);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (take) begin
          valid_d = 1'b1;
          if (sign_q) begin
            char_d = CHAR_MINUS;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d = CHAR_ZERO + {4'd0, top_dig};
            last_d = (cnt_q == DIG_CNT_W'(1));
            dig_d  = {dig_q[BCD_WIDTH-5:0], 4'd0};
            cnt_d  = cnt_q - DIG_CNT_W'(1);
            if (cnt_q == DIG_CNT_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      sign_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      sign_q  <= sign_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != ST_IDLE) || valid_q;
  assign out_valid_o = valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

FILE: rtl/core/int_to_decimal_ascii.sv
// first character: shift-and-add-3 over every input bit, handoff to the emitter, leading-zero skip,
//   then the output register
// requests: one at a time, the next is taken only after the last character has gone; a minus sign
//   and output stalls delay it further
// reset: asynchronous active low, clears all control state, no request pending
// depends on i2d_pkg, i2d_dabble, i2d_emit
module int_to_decimal_ascii
  import i2d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] value_bits_i,
  input  logic        is_signed_i,
  // character channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  text_char_o,
  output logic        last_char_o
);

  logic                   accept;
  logic                   cvt_busy;
  logic                   emit_busy;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] mag;
  cvt_status_t            cvt_status;
  logic [BCD_WIDTH-1:0]   bcd;

  // one request in flight, held off until its last character has gone
  assign in_stall_o = cvt_busy | emit_busy;
  assign accept     = in_valid_i & ~in_stall_o;

  // bits above the value width are ignored
  assign raw      = value_bits_i[VALUE_WIDTH-1:0];
  assign negative = is_signed_i & raw[VALUE_WIDTH-1];
  // unsigned magnitude, exact for the most negative value too
  assign mag      = negative ? (~raw + VALUE_WIDTH'(1)) : raw;

  // binary to bcd, one input bit per cycle
  i2d_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .neg_i    (negative),
    .mag_i    (mag),
    .busy_o   (cvt_busy),
    .status_o (cvt_status),
    .bcd_o    (bcd)
  );

  // sign and significant digits out through a registered output stage
  i2d_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (cvt_status),
    .bcd_i       (bcd),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

endmodule
